### hw/rtl/stsm_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted timer slot manager: command and status codes,
// transfer payload structs and the chain operation struct. No dependencies.
package stsm_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned MAX_FIRE  = 16;
  localparam int unsigned FIRE_W    = $clog2(MAX_FIRE);

  typedef enum logic [2:0] {
    CMD_ALLOC  = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_TAG    = 3'd2,
    CMD_ARM    = 3'd3,
    CMD_CANCEL = 3'd4,
    CMD_TICK   = 3'd5
  } cmd_e;

  localparam logic [1:0] RS_OK        = 2'd0;
  localparam logic [1:0] RS_NO_SLOT   = 2'd1;
  localparam logic [1:0] RS_NOT_ARMED = 2'd2;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_ARMED = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  slot;
    logic [31:0] delay_ticks;
    logic [7:0]  tag;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic        fired;
    logic [7:0]  tag_out;
    logic [31:0] earliest_deadline;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_out;
    logic       fired;
    logic [7:0] tag_out;
  } res_t;

  typedef struct packed {
    logic insert;
    logic remove;
    logic pop;
  } chain_op_t;

endpackage

### hw/rtl/sorted_timer_slot_manager.sv
`timescale 1ns / 1ps
// Sorted timer slot manager: command sequencer over a chain of stsm_cell.
// Steps: allocate, free, set tag and cancel go through the result buffer to the output
// register; arm unlinks, then inserts; tick pops each due timer, then emits the results.
// One command in flight; results leave one per cycle, while the output is not stalled, from a result buffer.
// Reset (async, active low): tick count zero, all slots free, chain empty.
module sorted_timer_slot_manager #(
  parameter int unsigned Slots = stsm_pkg::SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  stsm_pkg::in_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output stsm_pkg::out_t out_o
);
  import stsm_pkg::*;

  localparam int unsigned SlotW = $clog2(Slots);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [31:0]       count_q, count_d;
  logic [1:0]        status_q [Slots];
  logic [1:0]        status_d [Slots];
  logic [FIRE_W:0]   nf_q, nf_d;
  logic [FIRE_W:0]   idx_q, idx_d;
  logic [FIRE_W:0]   nres_q, nres_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        tag_q [Slots];
  res_t              buf_q [MAX_FIRE];
  logic [SlotW-1:0]  key_q;
  logic [31:0]       dl_q;
  out_t              out_q;

  chain_op_t         op;
  logic [SlotW-1:0]  key;
  logic              buf_we, tag_we, arm_ld, out_ld;
  logic [FIRE_W-1:0] buf_wix;
  res_t              buf_wd;

  logic [Slots-1:0]  cv, cb, ch;
  logic [SlotW-1:0]  cs [Slots];
  logic [31:0]       cd [Slots];

  logic              slot_ok, armed, free_found, head_due, last;
  logic [SlotW-1:0]  slot_ix, free_ix;
  logic [31:0]       earliest;

  for (genvar i = 0; i < Slots; i++) begin : g_cell
    logic             lv, lb, lh, rv;
    logic [SlotW-1:0] ls, rs;
    logic [31:0]      ld, rd;
    if (i == 0) begin : g_first
      assign lv = 1'b0;
      assign ls = '0;
      assign ld = '0;
      assign lb = 1'b0;
      assign lh = 1'b0;
    end else begin : g_mid
      assign lv = cv[i-1];
      assign ls = cs[i-1];
      assign ld = cd[i-1];
      assign lb = cb[i-1];
      assign lh = ch[i-1];
    end
    if (i == Slots - 1) begin : g_end
      assign rv = 1'b0;
      assign rs = '0;
      assign rd = '0;
    end else begin : g_inner
      assign rv = cv[i+1];
      assign rs = cs[i+1];
      assign rd = cd[i+1];
    end
    stsm_cell #(.SlotW(SlotW)) u_cell (
      .clk_i,
      .rst_ni,
      .op_i         (op),
      .key_i        (key),
      .dl_i         (dl_q),
      .left_valid_i (lv),
      .left_slot_i  (ls),
      .left_dl_i    (ld),
      .left_before_i(lb),
      .left_hit_i   (lh),
      .right_valid_i(rv),
      .right_slot_i (rs),
      .right_dl_i   (rd),
      .valid_o      (cv[i]),
      .slot_o       (cs[i]),
      .dl_o         (cd[i]),
      .before_o     (cb[i]),
      .hit_o        (ch[i])
    );
  end

  assign slot_ok  = (32'(in_i.slot) < Slots);
  assign slot_ix  = SlotW'(in_i.slot);
  assign armed    = slot_ok && (status_q[slot_ix] == ST_ARMED);
  assign head_due = cv[0] && (cd[0] <= count_q);
  assign earliest = cv[0] ? cd[0] : 32'hFFFF_FFFF;
  assign last     = (idx_q == (nres_q - 1'b1));

  always_comb begin
    free_found = 1'b0;
    free_ix    = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (status_q[i] == ST_FREE) begin
        free_found = 1'b1;
        free_ix    = SlotW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    status_d    = status_q;
    nf_d        = nf_q;
    idx_d       = idx_q;
    nres_d      = nres_q;
    out_valid_d = out_valid_q;
    op          = '0;
    key         = slot_ix;
    buf_we      = 1'b0;
    buf_wix     = nf_q[FIRE_W-1:0];
    buf_wd      = '0;
    tag_we      = 1'b0;
    arm_ld      = 1'b0;
    out_ld      = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          buf_we  = 1'b1;
          buf_wix = '0;
          nres_d  = (FIRE_W+1)'(1);
          idx_d   = '0;
          state_d = S_EMIT;
          case (cmd_e'(in_i.command))
            CMD_ALLOC: begin
              if (free_found) begin
                status_d[free_ix] = ST_ALLOC;
                buf_wd.slot_out   = 4'(free_ix);
              end else begin
                buf_wd.status = RS_NO_SLOT;
              end
            end
            CMD_FREE: begin
              if (slot_ok) begin
                op.remove         = armed;
                status_d[slot_ix] = ST_FREE;
              end
            end
            CMD_TAG: begin
              tag_we = slot_ok;
            end
            CMD_ARM: begin
              if (slot_ok) begin
                op.remove = armed;
                arm_ld    = 1'b1;
                state_d   = S_INS;
              end
            end
            CMD_CANCEL: begin
              if (armed) begin
                op.remove         = 1'b1;
                status_d[slot_ix] = ST_ALLOC;
              end else begin
                buf_wd.status = RS_NOT_ARMED;
              end
            end
            CMD_TICK: begin
              buf_we  = 1'b0;
              count_d = count_q + 32'd1;
              nf_d    = '0;
              state_d = S_POP;
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        op.insert       = 1'b1;
        key             = key_q;
        status_d[key_q] = ST_ARMED;
        state_d         = S_EMIT;
      end
      S_POP: begin
        if (head_due && (nf_q < (FIRE_W+1)'(MAX_FIRE))) begin
          op.pop            = 1'b1;
          buf_we            = 1'b1;
          buf_wd.slot_out   = 4'(cs[0]);
          buf_wd.fired      = 1'b1;
          buf_wd.tag_out    = tag_q[cs[0]];
          status_d[cs[0]]   = ST_ALLOC;
          nf_d              = nf_q + 1'b1;
        end else begin
          if (nf_q == '0) begin
            buf_we  = 1'b1;
            buf_wix = '0;
            nres_d  = (FIRE_W+1)'(1);
          end else begin
            nres_d = nf_q;
          end
          idx_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_ld      = 1'b1;
          out_valid_d = 1'b1;
          idx_d       = idx_q + 1'b1;
          if (last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      nf_q        <= '0;
      idx_q       <= '0;
      nres_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Slots; i++) begin
        status_q[i] <= ST_FREE;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      nf_q        <= nf_d;
      idx_q       <= idx_d;
      nres_q      <= nres_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_q[slot_ix] <= in_i.tag;
    end
    if (buf_we) begin
      buf_q[buf_wix] <= buf_wd;
    end
    if (arm_ld) begin
      key_q <= slot_ix;
      dl_q  <= in_i.delay_ticks + count_q;
    end
    if (out_ld) begin
      out_q.status            <= buf_q[idx_q[FIRE_W-1:0]].status;
      out_q.slot_out          <= buf_q[idx_q[FIRE_W-1:0]].slot_out;
      out_q.fired             <= buf_q[idx_q[FIRE_W-1:0]].fired;
      out_q.tag_out           <= buf_q[idx_q[FIRE_W-1:0]].tag_out;
      out_q.earliest_deadline <= earliest;
      out_q.last              <= last;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("idle after transfer");
  a_chain_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cv ^ (cv >> 1))) else $error("chain has a gap");
  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.fired) |-> (out_o.status == RS_OK)) else $error("fire status");
  a_pop_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.pop |-> head_due) else $error("pop of a timer not due");
`endif

endmodule

### hw/rtl/stsm_cell.sv
`timescale 1ns / 1ps
// One cell of the deadline-ordered timer chain: holds one armed timer and
// shifts toward either neighbor on insert, remove and pop. Uses stsm_pkg.
module stsm_cell #(
  parameter int unsigned SlotW = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stsm_pkg::chain_op_t op_i,
  input  logic [SlotW-1:0]   key_i,
  input  logic [31:0]        dl_i,
  input  logic               left_valid_i,
  input  logic [SlotW-1:0]   left_slot_i,
  input  logic [31:0]        left_dl_i,
  input  logic               left_before_i,
  input  logic               left_hit_i,
  input  logic               right_valid_i,
  input  logic [SlotW-1:0]   right_slot_i,
  input  logic [31:0]        right_dl_i,
  output logic               valid_o,
  output logic [SlotW-1:0]   slot_o,
  output logic [31:0]        dl_o,
  output logic               before_o,
  output logic               hit_o
);
  import stsm_pkg::*;

  logic             valid_q, valid_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [31:0]      dl_q, dl_d;

  assign before_o = !valid_q || (dl_i <= dl_q);
  assign hit_o    = left_hit_i || (valid_q && (slot_q == key_i));

  always_comb begin
    valid_d = valid_q;
    slot_d  = slot_q;
    dl_d    = dl_q;
    priority if (op_i.pop || (op_i.remove && hit_o)) begin
      valid_d = right_valid_i;
      slot_d  = right_slot_i;
      dl_d    = right_dl_i;
    end else if (op_i.insert && left_before_i) begin
      valid_d = left_valid_i;
      slot_d  = left_slot_i;
      dl_d    = left_dl_i;
    end else if (op_i.insert && before_o) begin
      valid_d = 1'b1;
      slot_d  = key_i;
      dl_d    = dl_i;
    end else begin
      valid_d = valid_q;
      slot_d  = slot_q;
      dl_d    = dl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    dl_q   <= dl_d;
  end

  assign valid_o = valid_q;
  assign slot_o  = slot_q;
  assign dl_o    = dl_q;

endmodule

### tb/tb_sorted_timer_slot_manager.sv
`timescale 1ns / 1ps
// Testbench for sorted_timer_slot_manager: a directed table, then random command traffic,
// checked against a built-in model of the sorted timer list. Depends on stsm_pkg.
module tb_sorted_timer_slot_manager;
  import stsm_pkg::*;

  localparam int NSLOT = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    in_t  cmd;
    bit   typed;
    out_t want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;

  sorted_timer_slot_manager DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [31:0] tick_cnt = '0;
  logic [1:0]  slot_state [NSLOT];
  logic [31:0] slot_dl [NSLOT];
  logic [7:0]  slot_tag [NSLOT];
  bit          tag_known [NSLOT];
  int          armed_chain [$];
  out_t        pending_results [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int cmds_sent = 0;
  int results_seen = 0;
  int fires_seen = 0;
  int quiet_cycles = 0;

  function automatic logic [31:0] head_deadline();
    return (armed_chain.size() != 0) ? slot_dl[armed_chain[0]] : 32'hFFFF_FFFF;
  endfunction

  function automatic bit unlink_slot(int s);
    if (slot_state[s] != ST_ARMED) return 1'b0;
    foreach (armed_chain[i]) begin
      if (armed_chain[i] == s) begin
        armed_chain.delete(i);
        break;
      end
    end
    slot_state[s] = ST_ALLOC;
    return 1'b1;
  endfunction

  task automatic timer_list_apply(input in_t c, output out_t res [$]);
    int s;
    int n;
    int pos;
    int h;
    logic [31:0] dl;
    out_t r;
    bit was;
    s = c.slot;
    res = {};
    r = '0;
    case (c.command)
      CMD_ALLOC: begin
        for (n = 0; n < NSLOT; n++) if (slot_state[n] == ST_FREE) break;
        if (n < NSLOT) begin
          slot_state[n] = ST_ALLOC;
          r.slot_out = n[3:0];
        end else begin
          r.status = RS_NO_SLOT;
        end
        res.push_back(r);
      end
      CMD_FREE: begin
        was = unlink_slot(s);
        slot_state[s] = ST_FREE;
        res.push_back(r);
      end
      CMD_TAG: begin
        slot_tag[s] = c.tag;
        tag_known[s] = 1'b1;
        res.push_back(r);
      end
      CMD_ARM: begin
        was = unlink_slot(s);
        dl = c.delay_ticks + tick_cnt;
        slot_dl[s] = dl;
        slot_state[s] = ST_ARMED;
        pos = armed_chain.size();
        foreach (armed_chain[i]) begin
          if (dl <= slot_dl[armed_chain[i]]) begin
            pos = i;
            break;
          end
        end
        armed_chain.insert(pos, s);
        res.push_back(r);
      end
      CMD_CANCEL: begin
        r.status = unlink_slot(s) ? RS_OK : RS_NOT_ARMED;
        res.push_back(r);
      end
      CMD_TICK: begin
        tick_cnt = tick_cnt + 32'd1;
        while (res.size() < MAX_FIRE && armed_chain.size() != 0 &&
               slot_dl[armed_chain[0]] <= tick_cnt) begin
          h = armed_chain.pop_front();
          slot_state[h] = ST_ALLOC;
          r = '0;
          r.slot_out = h[3:0];
          r.fired = 1'b1;
          r.tag_out = slot_tag[h];
          res.push_back(r);
        end
        if (res.size() == 0) res.push_back('0);
      end
      default: res.push_back(r);
    endcase
    foreach (res[i]) res[i].earliest_deadline = head_deadline();
    res[res.size()-1].last = 1'b1;
  endtask

  task automatic transfer_cmd(input in_t c, input bit typed = 1'b0, input out_t want = '0);
    out_t res [$];
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    timer_list_apply(c, res);
    if (typed) res = '{want};
    foreach (res[i]) pending_results.push_back(res[i]);
    cmds_sent++;
  endtask

  function automatic in_t mk(cmd_e op, int s, logic [31:0] d, logic [7:0] t);
    in_t c;
    c.command = op;
    c.slot = s[3:0];
    c.delay_ticks = d;
    c.tag = t;
    return c;
  endfunction

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_t exp_r;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_o.fired) fires_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %p", $time, out_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_o.status !== exp_r.status || out_o.slot_out !== exp_r.slot_out ||
            out_o.fired !== exp_r.fired || out_o.tag_out !== exp_r.tag_out ||
            out_o.earliest_deadline !== exp_r.earliest_deadline ||
            out_o.last !== exp_r.last) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_o);
        end
      end
    end
    if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog timeout, %0d results outstanding", $time, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [$];
    in_t c;
    int pick;
    int s;
    logic [31:0] d;
    for (int i = 0; i < NSLOT; i++) begin
      slot_state[i] = ST_FREE;
      slot_dl[i] = '0;
      slot_tag[i] = '0;
      tag_known[i] = 1'b0;
    end
    plan.push_back('{mk(CMD_TICK, 0, 0, 0), 1, '{RS_OK, 0, 0, 0, 32'hFFFF_FFFF, 1}});
    plan.push_back('{mk(CMD_CANCEL, 3, 0, 0), 1, '{RS_NOT_ARMED, 0, 0, 0, 32'hFFFF_FFFF, 1}});
    plan.push_back('{mk(CMD_ALLOC, 0, 0, 0), 1, '{RS_OK, 0, 0, 0, 32'hFFFF_FFFF, 1}});
    plan.push_back('{mk(CMD_TAG, 0, 0, 8'hFF), 1, '{RS_OK, 0, 0, 0, 32'hFFFF_FFFF, 1}});
    plan.push_back('{mk(CMD_TAG, 1, 0, 8'h00), 1, '{RS_OK, 0, 0, 0, 32'hFFFF_FFFF, 1}});
    plan.push_back('{mk(CMD_TAG, 15, 0, 8'hA5), 1, '{RS_OK, 0, 0, 0, 32'hFFFF_FFFF, 1}});
    plan.push_back('{mk(CMD_ARM, 0, 32'hFFFF_FFFF, 0), 0, '0});
    plan.push_back('{mk(CMD_ARM, 1, 0, 0), 0, '0});
    plan.push_back('{mk(CMD_ARM, 15, 1, 0), 0, '0});
    plan.push_back('{mk(CMD_TICK, 0, 0, 0), 0, '0});
    plan.push_back('{mk(CMD_ARM, 1, 5, 0), 0, '0});
    plan.push_back('{mk(CMD_ARM, 1, 3, 0), 0, '0});
    plan.push_back('{mk(CMD_CANCEL, 1, 0, 0), 0, '0});
    plan.push_back('{mk(CMD_CANCEL, 1, 0, 0), 0, '0});
    plan.push_back('{mk(CMD_ARM, 0, 2, 0), 0, '0});
    plan.push_back('{mk(CMD_FREE, 0, 0, 0), 0, '0});
    plan.push_back('{mk(CMD_ARM, 1, 4, 0), 0, '0});
    plan.push_back('{mk(CMD_ARM, 0, 4, 0), 0, '0});
    plan.push_back('{in_t'{3'd6, 4'd2, 32'h1234_5678, 8'h5A}, 0, '0});
    plan.push_back('{in_t'{3'd7, 4'd9, 32'hFFFF_FFFF, 8'hFF}, 0, '0});
    plan.push_back('{mk(CMD_ARM, 15, 32'h8000_0000, 0), 0, '0});
    plan.push_back('{mk(CMD_TICK, 0, 0, 0), 0, '0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) transfer_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
    repeat (NSLOT + 1) transfer_cmd(mk(CMD_ALLOC, 0, 0, 0));
    for (int i = 0; i < NSLOT; i++) begin
      transfer_cmd(mk(CMD_TAG, i, 0, 8'($urandom_range(0, 255))));
      transfer_cmd(mk(CMD_ARM, i, 1, 0));
    end
    transfer_cmd(mk(CMD_TICK, 0, 0, 0));
    in_valid_i <= 1'b0;
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int n = 0; n < 27; n++) begin
        pick = $urandom_range(0, 99);
        s = $urandom_range(0, NSLOT - 1);
        d = $urandom_range(0, 12);
        case ($urandom_range(0, 9))
          0, 1: d = $urandom;
          2: d = 32'hFFFF_FFFF;
          default: ;
        endcase
        if (pick < 12) c = mk(CMD_ALLOC, s, $urandom, 8'($urandom));
        else if (pick < 22) c = mk(CMD_FREE, s, $urandom, 8'($urandom));
        else if (pick < 32) c = mk(CMD_TAG, s, $urandom, 8'($urandom));
        else if (pick < 62) c = mk(CMD_ARM, s, d, 8'($urandom));
        else if (pick < 72) c = mk(CMD_CANCEL, s, $urandom, 8'($urandom));
        else if (pick < 97) c = mk(CMD_TICK, s, $urandom, 8'($urandom));
        else c = in_t'{3'($urandom_range(6, 7)), 4'(s), 32'($urandom), 8'($urandom)};
        if (c.command == CMD_ARM && !tag_known[s])
          transfer_cmd(mk(CMD_TAG, s, 0, 8'($urandom_range(0, 255))));
        transfer_cmd(c);
      end
      in_valid_i <= 1'b0;
      drain_results();
    end

    repeat (40) @(posedge clk_i);
    $display("Covered %0d commands and %0d results, %0d of them expirations,",
             cmds_sent, results_seen, fires_seen);
    $display("over directed extremes and four handshake pressure phases.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
